### src/cpu16_pkg.sv
// -----------------------------------------------------------------------------
// cpu16_pkg: shared types and constants
// Opcodes, mode bits, sequencer states and the input and result structs of
// the 16-bit execute unit.
// -----------------------------------------------------------------------------
`default_nettype none
package cpu16_pkg;

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_OR    = 4'd5;
  localparam logic [3:0] OP_AND   = 4'd6;
  localparam logic [3:0] OP_XOR   = 4'd7;
  localparam logic [3:0] OP_SHIFT = 4'd8;
  localparam logic [3:0] OP_NOT   = 4'd9;
  localparam logic [3:0] OP_PUSH  = 4'd10;
  localparam logic [3:0] OP_POP   = 4'd11;
  localparam logic [3:0] OP_STORE = 4'd12;
  localparam logic [3:0] OP_LOAD  = 4'd13;
  localparam logic [3:0] OP_CMP   = 4'd14;
  localparam logic [3:0] OP_JMP   = 4'd15;

  localparam logic [3:0] SP_REG   = 4'd10;
  localparam logic [3:0] FLAG_REG = 4'd11;

  localparam logic [15:0] IO_BASE   = 16'hF000;
  localparam logic [15:0] FLAG_LESS = 16'h8000;
  localparam logic [15:0] FLAG_GT   = 16'h4000;
  localparam logic [15:0] FLAG_EQ   = 16'h2000;
  localparam logic [15:0] FLAG_ZERO = 16'h1000;
  localparam logic [15:0] FLAG_KEEP = 16'h0FFF;

  typedef enum logic [3:0] {
    ST_CLEAR,   // memory clearing sweep after reset
    ST_IDLE,
    ST_EXEC,    // operands ready; ALU, compare and jump ops finish here
    ST_DIV,     // one quotient bit per cycle
    ST_MEM0,    // first store byte, or read of each load byte
    ST_MEM1,    // second store byte
    ST_MEMW,    // register the read byte
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  mode_bits;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic [15:0] immediate;
    logic        second_pass;
    logic [15:0] instr_pc;
    logic [15:0] predicted_pc;
    logic [15:0] io_read_data;
  } in_item_t;

  typedef struct packed {
    logic        done_res;
    logic        redirect;
    logic [15:0] redirect_pc;
    logic        io_write;
    logic        io_read;
    logic        io_byte;
    logic [15:0] io_addr;
    logic [15:0] io_data;
  } out_item_t;

endpackage
`default_nettype wire

### src/cpu16_execute_unit_core.sv
// -----------------------------------------------------------------------------
// cpu16_execute_unit_core: execute stage of a 16-bit machine
// Register file, byte data memory, shared 16-bit adder/subtractor unit used
// by a small sequencer for ALU ops, division, addressing and jumps.
// -----------------------------------------------------------------------------
// Per item: ALU/compare/jump ops pass ST_EXEC, ST_DONE; stores (push, call too)
// add ST_MEM0, ST_MEM1 for a second byte; loads (pop too) add ST_MEM0, ST_MEMW
// per byte (one data memory port); divide adds ST_DIV, one quotient bit per cycle
// through the shared subtractor. busy stays high for the whole item; the next
// start is taken the cycle after out_valid. Reset: the register file clears at
// once; a sweep clears all MEM_BYTES memory bytes, busy high meanwhile. The receiver cannot stall.
`default_nettype none
module cpu16_execute_unit_core #(
  parameter int MEM_BYTES = 16384,
  parameter int NUM_REGS  = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  cpu16_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output cpu16_pkg::out_item_t  out_item,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [13:0]           cfg_user_mem_limit
);
  import cpu16_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  // storage
  logic [15:0] regs_r [NUM_REGS];
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_rd_r;

  logic [13:0] limit_r;
  state_t      state_r, state_nxt;
  in_item_t    it_r;
  logic [15:0] a_r, b_r, x_r, y_r;
  logic [15:0] acc_r, acc_nxt;        // remainder / result
  logic [15:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [AW:0] clr_r;
  logic [15:0] addr_r, addr_nxt;      // memory address of current byte
  logic [1:0]  nbytes_r, nbytes_nxt;  // bytes still to access
  out_item_t   res_r, res_nxt;
  logic [15:0] wdata_r, wdata_nxt;    // value to store or loaded value
  logic        wr_en_r, wr_en_nxt;    // pending register write at ST_DONE
  logic [3:0]  wr_idx_r, wr_idx_nxt;
  logic        sp_en_r, sp_en_nxt;    // pending stack pointer write
  logic [15:0] sp_val_r, sp_val_nxt;
  logic        is_store_r, is_store_nxt;

  function automatic logic [15:0] rd(input logic [3:0] i);
    logic [15:0] v;
    v = 16'd0;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (i == 4'(k)) begin
        v = regs_r[k];
      end
    end
    return v;
  endfunction

  // shared adder: sum/difference/compare
  logic [15:0] alu_p, alu_q;
  logic        alu_sub;
  logic [16:0] alu_s;
  always_comb begin
    alu_s = {1'b0, alu_p} + {1'b0, (alu_sub ? ~alu_q : alu_q)} + {16'd0, alu_sub};
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_DONE);
  assign out_item  = res_r;

  // in-range address for data memory
  function automatic logic in_mem(input logic [15:0] a);
    return {16'd0, a} < 32'(MEM_BYTES);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == (AW+1)'(MEM_BYTES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (it_r.func == OP_DIV) state_nxt = ST_DIV;
        else if (nbytes_nxt != 2'd0) state_nxt = ST_MEM0;
        else state_nxt = ST_DONE;
      end
      ST_DIV:   if (cnt_r == 5'd0) state_nxt = ST_DONE;
      ST_MEM0:  state_nxt = is_store_r ? ((nbytes_r == 2'd2) ? ST_MEM1 : ST_DONE) : ST_MEMW;
      ST_MEM1:  state_nxt = ST_DONE;
      ST_MEMW:  state_nxt = (nbytes_r == 2'd2) ? ST_MEM0 : ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  logic [15:0] ea, jt, flags, cmp_r, dval;
  logic        take, lim_hit;
  always_comb begin
    alu_p = 16'd0; alu_q = 16'd0; alu_sub = 1'b0;
    acc_nxt = acc_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    addr_nxt = addr_r; nbytes_nxt = nbytes_r;
    res_nxt = res_r; wdata_nxt = wdata_r;
    wr_en_nxt = wr_en_r; wr_idx_nxt = wr_idx_r;
    sp_en_nxt = sp_en_r; sp_val_nxt = sp_val_r; is_store_nxt = is_store_r;
    ea = 16'd0; jt = 16'd0; flags = rd(FLAG_REG); take = 1'b1; cmp_r = 16'd0;
    dval = rd(it_r.dest_reg);
    lim_hit = 1'b0;
    case (state_r)
      ST_EXEC: begin
        res_nxt = '0;
        res_nxt.done_res = 1'b1;
        wr_en_nxt = 1'b0; sp_en_nxt = 1'b0; nbytes_nxt = 2'd0;
        wr_idx_nxt = it_r.dest_reg; is_store_nxt = 1'b0;
        case (it_r.func)
          OP_ADD: begin alu_p = a_r; alu_q = b_r; wdata_nxt = alu_s[15:0]; wr_en_nxt = 1'b1; end
          OP_SUB: begin
            alu_p = x_r; alu_q = y_r; alu_sub = 1'b1;
            wdata_nxt = alu_s[15:0]; wr_en_nxt = 1'b1;
          end
          OP_MUL: begin wdata_nxt = 16'(a_r * b_r); wr_en_nxt = 1'b1; end
          OP_DIV: begin acc_nxt = 16'd0; quo_nxt = x_r; cnt_nxt = 5'd16; end
          OP_OR:  begin wdata_nxt = a_r | b_r; wr_en_nxt = 1'b1; end
          OP_AND: begin wdata_nxt = a_r & b_r; wr_en_nxt = 1'b1; end
          OP_XOR: begin wdata_nxt = a_r ^ b_r; wr_en_nxt = 1'b1; end
          OP_SHIFT: begin
            if (y_r[15:4] != 12'd0) wdata_nxt = 16'd0;
            else if (it_r.mode_bits[1]) wdata_nxt = x_r << y_r[3:0];
            else wdata_nxt = x_r >> y_r[3:0];
            wr_en_nxt = 1'b1;
          end
          OP_NOT: begin wdata_nxt = ~a_r; wr_en_nxt = 1'b1; end
          OP_PUSH: begin
            alu_p = rd(SP_REG); alu_q = 16'd2; alu_sub = 1'b1;
            sp_en_nxt = 1'b1; sp_val_nxt = alu_s[15:0];
            addr_nxt = alu_s[15:0]; nbytes_nxt = 2'd2; is_store_nxt = 1'b1;
            wdata_nxt = (it_r.dest_reg == SP_REG) ? alu_s[15:0] : dval;
          end
          OP_POP: begin
            addr_nxt = rd(SP_REG); nbytes_nxt = 2'd2; wr_en_nxt = 1'b1;
            wdata_nxt = 16'd0;
            alu_p = rd(SP_REG); alu_q = 16'd2;
            sp_en_nxt = 1'b1; sp_val_nxt = alu_s[15:0];
          end
          OP_STORE, OP_LOAD: begin
            alu_p = a_r; alu_q = b_r; ea = alu_s[15:0];
            // past the limit when the last byte of the access lies above it
            lim_hit = ({1'b0, ea} + {16'd0, ~it_r.mode_bits[2]}) > {3'd0, limit_r};
            if (lim_hit && ea < IO_BASE) ea = 16'd0;
            if (ea >= IO_BASE) begin
              res_nxt.io_addr = ea;
              res_nxt.io_byte = it_r.mode_bits[2];
              if (it_r.func == OP_STORE) begin
                res_nxt.io_write = 1'b1;
                res_nxt.io_data = it_r.mode_bits[2] ? {8'd0, dval[7:0]} : dval;
              end else begin
                res_nxt.io_read = 1'b1;
                wr_en_nxt = 1'b1;
                wdata_nxt = it_r.mode_bits[2] ? {8'd0, it_r.io_read_data[7:0]}
                                              : it_r.io_read_data;
              end
            end else begin
              addr_nxt = ea;
              nbytes_nxt = it_r.mode_bits[2] ? 2'd1 : 2'd2;
              is_store_nxt = (it_r.func == OP_STORE);
              if (it_r.func == OP_STORE) begin
                wdata_nxt = it_r.mode_bits[2] ? {dval[7:0], 8'd0} : dval;
              end else begin
                wr_en_nxt = 1'b1; wdata_nxt = 16'd0;
              end
            end
          end
          OP_CMP: begin
            alu_p = x_r; alu_q = y_r; alu_sub = 1'b1;
            cmp_r = flags & FLAG_KEEP;
            if (!alu_s[16]) cmp_r = cmp_r | FLAG_LESS;
            if (alu_s[16] && alu_s[15:0] != 16'd0) cmp_r = cmp_r | FLAG_GT;
            if (alu_s[15:0] == 16'd0) cmp_r = cmp_r | FLAG_EQ;
            if (x_r == 16'd0 && y_r == 16'd0) cmp_r = cmp_r | FLAG_ZERO;
            wdata_nxt = cmp_r; wr_en_nxt = 1'b1; wr_idx_nxt = FLAG_REG;
          end
          OP_JMP: begin
            alu_p = a_r; alu_q = b_r; jt = alu_s[15:0];
            // a jump target spans four bytes
            if (({1'b0, jt} + 17'd3) > {3'd0, limit_r}) jt = 16'd0;
            if (it_r.mode_bits[0] && !flags[15]) take = 1'b0;
            if (it_r.dest_reg[2] && !flags[14]) take = 1'b0;
            if (it_r.dest_reg[3] && !flags[13]) take = 1'b0;
            if (it_r.dest_reg[1]) take = !take;
            if (take && !it_r.second_pass && it_r.dest_reg[0]) begin
              res_nxt.done_res = 1'b0;
              sp_en_nxt = 1'b1; sp_val_nxt = rd(SP_REG) - 16'd2;
              addr_nxt = rd(SP_REG) - 16'd2; nbytes_nxt = 2'd2; is_store_nxt = 1'b1;
              wdata_nxt = it_r.instr_pc + 16'd4;
            end else begin
              if (!take) jt = it_r.instr_pc + 16'd4;
              if (it_r.predicted_pc != jt) begin
                res_nxt.redirect = 1'b1; res_nxt.redirect_pc = jt;
              end
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        // restoring division, one bit per cycle
        alu_p = {acc_r[14:0], quo_r[15]}; alu_q = y_r; alu_sub = 1'b1;
        if (cnt_r != 5'd0) begin
          if (acc_r[15] || alu_s[16]) begin
            acc_nxt = alu_s[15:0]; quo_nxt = {quo_r[14:0], 1'b1};
          end else begin
            acc_nxt = alu_p; quo_nxt = {quo_r[14:0], 1'b0};
          end
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          wr_en_nxt = 1'b1;
          if (it_r.mode_bits[1]) wdata_nxt = (y_r == 16'd0) ? x_r : acc_r;
          else wdata_nxt = (y_r == 16'd0) ? 16'hFFFF : quo_r;
        end
      end
      ST_MEM0: begin
        if (is_store_r) begin
          addr_nxt = addr_r + 16'd1;
          wdata_nxt = {wdata_r[7:0], 8'd0};
          nbytes_nxt = nbytes_r - 2'd1;
        end
      end
      ST_MEMW: begin
        wdata_nxt = {wdata_r[7:0], (in_mem(addr_r) ? mem_rd_r : 8'd0)};
        addr_nxt = addr_r + 16'd1;
        nbytes_nxt = nbytes_r - 2'd1;
      end
      default: ;
    endcase
  end

  // register file, memory and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      limit_r <= 14'h3FFF;
      for (int k = 0; k < NUM_REGS; k++) regs_r[k] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_user_mem_limit;
      if (state_r == ST_CLEAR) begin
        mem[clr_r[AW-1:0]] <= 8'd0;
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_MEM0 && is_store_r && in_mem(addr_r)) begin
        mem[addr_r[AW-1:0]] <= wdata_r[15:8];
      end
      if (state_r == ST_MEM1 && in_mem(addr_r)) begin
        mem[addr_r[AW-1:0]] <= wdata_r[15:8];
      end
      // commit: stack pointer first, then destination (pop into sp wins)
      if (state_r == ST_DONE) begin
        if (sp_en_r && NUM_REGS > int'(SP_REG)) regs_r[SP_REG] <= sp_val_r;
        if (wr_en_r) begin
          for (int k = 0; k < NUM_REGS; k++) begin
            if (wr_idx_r == 4'(k)) begin
              regs_r[k] <= (it_r.func == OP_POP && wr_idx_r == SP_REG)
                           ? wdata_r + 16'd2 : wdata_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mem_rd_r <= mem[addr_r[AW-1:0]];
    acc_r <= acc_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    addr_r <= addr_nxt; nbytes_r <= nbytes_nxt; res_r <= res_nxt;
    wdata_r <= wdata_nxt; wr_en_r <= wr_en_nxt; wr_idx_r <= wr_idx_nxt;
    sp_en_r <= sp_en_nxt; sp_val_r <= sp_val_nxt; is_store_r <= is_store_nxt;
    if (state_r == ST_IDLE && start) begin
      // latch item and fetch operands
      it_r <= in_item;
      a_r <= rd(in_item.base_reg);
      b_r <= in_item.mode_bits[3] ? rd(in_item.immediate[3:0]) : in_item.immediate;
      if (!in_item.mode_bits[3] && in_item.mode_bits[2]) begin
        x_r <= in_item.immediate; y_r <= rd(in_item.base_reg);
      end else begin
        x_r <= rd(in_item.base_reg);
        y_r <= in_item.mode_bits[3] ? rd(in_item.immediate[3:0]) : in_item.immediate;
      end
    end
  end

endmodule
`default_nettype wire
